@@ design/cst_pkg.sv @@
// Shared types and constants of the cosine/sine Taylor pipeline.
package cst_pkg;

	// operation codes
	localparam logic OP_COS = 1'b0;
	localparam logic OP_SIN = 1'b1;

	// Q2.30 one, and the Q4.28 angle constants (rounded to nearest)
	localparam logic [31:0] Q_ONE     = 32'd1073741824;
	localparam logic [31:0] HALF_PI_Q = 32'd421657428;
	localparam logic [31:0] PI_Q      = 32'd843314857;
	localparam logic [31:0] TWO_PI_Q  = 32'd1686629713;

	localparam int NSTEP    = 7;   // Horner steps
	localparam int FRAC_W   = 30;  // fraction bits of s, q and t
	localparam int R_W      = 30;  // reduced angle, below pi
	localparam int S_W      = 34;  // s = r*r in Q.30
	localparam int Q_W      = 33;  // s / d, largest for d = 2
	localparam int TC_W     = 31;  // clamped t in [0, 1]
	localparam int PROD_W   = Q_W + TC_W;
	localparam int P_W      = PROD_W - FRAC_W;
	localparam int T_W      = P_W + 2;
	localparam int RECIP_W  = 34;
	localparam int RECIP_SH = 33;  // reciprocal scale 2^33
	localparam int ODD_W    = 7;

	// divisor d = 2^shift * odd, innermost step first: 182 132 90 56 30 12 2
	localparam logic [1:0] DIV_SHIFT [NSTEP] = '{2'd1, 2'd2, 2'd1, 2'd3, 2'd1, 2'd2, 2'd1};
	localparam logic [ODD_W-1:0] DIV_ODD [NSTEP] =
		'{7'd91, 7'd33, 7'd45, 7'd7, 7'd15, 7'd3, 7'd1};
	// floor(2^33 / odd)
	localparam logic [RECIP_W-1:0] DIV_RECIP [NSTEP] = '{
		34'd94394885, 34'd260301048, 34'd190887435, 34'd1227133513,
		34'd572662306, 34'd2863311530, 34'd8589934592
	};

	typedef logic [NSTEP-1:0][Q_W-1:0] q_vec_t;

	typedef struct packed {
		logic valid;
		logic neg;
	} ctl_t;

endpackage

@@ design/cst_div.sv @@
// Seven parallel divisions of s by the Horner divisors, two register stages.
module cst_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cst_pkg::ctl_t         ctl_in,
	input  logic [cst_pkg::S_W-1:0] s_in,
	output cst_pkg::ctl_t         ctl_out,
	output cst_pkg::q_vec_t       q_out
);

	localparam int DW = cst_pkg::Q_W + cst_pkg::RECIP_W;

	cst_pkg::ctl_t                ctl_s1, ctl_s2;
	logic [cst_pkg::Q_W-1:0]      x_s1    [cst_pkg::NSTEP];
	logic [DW-1:0]                prod_s1 [cst_pkg::NSTEP];
	cst_pkg::q_vec_t              q_s2;
	cst_pkg::q_vec_t              q_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	// stage 1: strip the power of two, multiply by the reciprocal of the odd part
	always_ff @(posedge clk) begin
		for (int i = 0; i < cst_pkg::NSTEP; i++) begin
			x_s1[i]    <= cst_pkg::Q_W'(s_in >> cst_pkg::DIV_SHIFT[i]);
			prod_s1[i] <= DW'(cst_pkg::Q_W'(s_in >> cst_pkg::DIV_SHIFT[i]))
				* DW'(cst_pkg::DIV_RECIP[i]);
		end
	end

	// stage 2: estimate is exact or one short; fix it with the remainder
	always_comb begin
		logic [cst_pkg::Q_W-1:0] q0;
		logic [cst_pkg::Q_W:0]   rem;
		for (int i = 0; i < cst_pkg::NSTEP; i++) begin
			q0  = prod_s1[i][cst_pkg::RECIP_SH +: cst_pkg::Q_W];
			rem = {1'b0, x_s1[i]}
				- ((cst_pkg::Q_W + 1)'(q0) * (cst_pkg::Q_W + 1)'(cst_pkg::DIV_ODD[i]));
			q_c[i] = q0 + cst_pkg::Q_W'(rem >= (cst_pkg::Q_W + 1)'(cst_pkg::DIV_ODD[i]));
		end
	end

	always_ff @(posedge clk) begin
		q_s2 <= q_c;
	end

	assign ctl_out = ctl_s2;
	assign q_out   = q_s2;

endmodule

@@ design/cst_horner.sv @@
// Horner chain of the cosine series, one multiply per register stage.
module cst_horner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cst_pkg::ctl_t                 ctl_in,
	input  cst_pkg::q_vec_t               q_in,
	output cst_pkg::ctl_t                 ctl_out,
	output logic signed [cst_pkg::T_W-1:0] t_out
);

	cst_pkg::ctl_t                  ctl_s  [cst_pkg::NSTEP];
	cst_pkg::q_vec_t                q_s    [cst_pkg::NSTEP];
	logic [cst_pkg::PROD_W-1:0]     prod_s [cst_pkg::NSTEP];
	logic [cst_pkg::PROD_W-1:0]     prod_c [cst_pkg::NSTEP];

	// t = 1 - p, held to [0, 1] before the next product
	function automatic logic [cst_pkg::TC_W-1:0] next_tc(input logic [cst_pkg::PROD_W-1:0] prod);
		logic signed [cst_pkg::T_W-1:0] t;
		t = $signed(cst_pkg::T_W'(cst_pkg::Q_ONE))
			- $signed({2'b00, prod[cst_pkg::PROD_W-1:cst_pkg::FRAC_W]});
		if (t < 0)
			return '0;
		else if (t > $signed(cst_pkg::T_W'(cst_pkg::Q_ONE)))
			return cst_pkg::TC_W'(cst_pkg::Q_ONE);
		else
			return t[cst_pkg::TC_W-1:0];
	endfunction

	always_comb begin
		prod_c[0] = cst_pkg::PROD_W'(q_in[0]) * cst_pkg::PROD_W'(cst_pkg::Q_ONE);
		for (int j = 1; j < cst_pkg::NSTEP; j++) begin
			prod_c[j] = cst_pkg::PROD_W'(q_s[j-1][j])
				* cst_pkg::PROD_W'(next_tc(prod_s[j-1]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < cst_pkg::NSTEP; j++)
				ctl_s[j] <= '0;
		end else begin
			ctl_s[0] <= ctl_in;
			for (int j = 1; j < cst_pkg::NSTEP; j++)
				ctl_s[j] <= ctl_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		q_s[0]    <= q_in;
		prod_s[0] <= prod_c[0];
		for (int j = 1; j < cst_pkg::NSTEP; j++) begin
			q_s[j]    <= q_s[j-1];
			prod_s[j] <= prod_c[j];
		end
	end

	assign ctl_out = ctl_s[cst_pkg::NSTEP-1];
	assign t_out   = $signed(cst_pkg::T_W'(cst_pkg::Q_ONE))
		- $signed({2'b00, prod_s[cst_pkg::NSTEP-1][cst_pkg::PROD_W-1:cst_pkg::FRAC_W]});

endmodule

@@ design/cosine_sine_taylor_top.sv @@
// Top level of the fixed-point cosine/sine pipeline.
// Cosine or sine of a Q4.28 angle (operation 0 = cosine, 1 = sine), returned as
// Q2.30 saturated to [-1, 1]. The block is a fixed 14-stage pipeline: an item
// is taken on every edge where start is high, busy never rises, and the result
// appears on value with done high for a single cycle. Results come out in the
// order the angles went in. Throughput is one item per clock; the pipeline is
// made of the seven-step Horner chain (one multiplier and register per step),
// two stages of constant division and four stages of range reduction and
// squaring, plus the output register.
module cosine_sine_taylor_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic signed [31:0] angle,
	output logic               done,
	output logic signed [31:0] value
);

	localparam int LATENCY = 4 + 2 + cst_pkg::NSTEP + 1;
	localparam logic signed [cst_pkg::T_W-1:0] ONE_T = cst_pkg::T_W'(cst_pkg::Q_ONE);

	// s1: sine offset and magnitude
	logic                       v_s1;
	logic [31:0]                mag_s1;
	// s2: full-turn removal
	logic                       v_s2;
	logic [30:0]                red_s2;
	// s3: half-turn removal, sign of the result decided here
	cst_pkg::ctl_t              ctl_s3;
	logic [cst_pkg::R_W-1:0]    r_s3;
	// s4: square, truncated to Q.30
	cst_pkg::ctl_t              ctl_s4;
	logic [cst_pkg::S_W-1:0]    s_s4;
	// s14: output register
	logic                       done_s14;
	logic signed [31:0]         value_s14;

	logic signed [33:0]         off_c;
	logic [31:0]                mag_c;
	logic [31:0]                red1_c, red2_c;
	logic [2*cst_pkg::R_W-1:0]  sq_c;

	cst_pkg::ctl_t              div_ctl, hor_ctl;
	cst_pkg::q_vec_t            div_q;
	logic signed [cst_pkg::T_W-1:0] hor_t;
	logic signed [cst_pkg::T_W-1:0] sgn_c;
	logic signed [31:0]         sat_c;

	// nothing downstream can hold us off, so the pipeline never stalls
	assign busy = 1'b0;

	always_comb begin
		off_c = {{2{angle[31]}}, angle}
			- ((operation == cst_pkg::OP_SIN) ? 34'({2'b00, cst_pkg::HALF_PI_Q}) : 34'sd0);
		mag_c = off_c[33] ? 32'(34'sd0 - off_c) : off_c[31:0];
	end

	// magnitude stays below 4*pi, so the second pass is a safeguard only
	always_comb begin
		red1_c = (mag_s1 >= cst_pkg::TWO_PI_Q) ? mag_s1 - cst_pkg::TWO_PI_Q : mag_s1;
		red2_c = (red1_c >= cst_pkg::TWO_PI_Q) ? red1_c - cst_pkg::TWO_PI_Q : red1_c;
	end

	assign sq_c = (2*cst_pkg::R_W)'(r_s3) * (2*cst_pkg::R_W)'(r_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			ctl_s3   <= '0;
			ctl_s4   <= '0;
			done_s14 <= 1'b0;
		end else begin
			v_s1         <= start & ~busy;
			v_s2         <= v_s1;
			ctl_s3.valid <= v_s2;
			ctl_s3.neg   <= {1'b0, red_s2} >= cst_pkg::PI_Q;
			ctl_s4       <= ctl_s3;
			done_s14     <= hor_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag_c;
		red_s2 <= red2_c[30:0];
		if ({1'b0, red_s2} >= cst_pkg::PI_Q)
			r_s3 <= cst_pkg::R_W'({1'b0, red_s2} - cst_pkg::PI_Q);
		else
			r_s3 <= red_s2[cst_pkg::R_W-1:0];
		s_s4      <= sq_c[2*cst_pkg::R_W-1 -: cst_pkg::S_W];
		value_s14 <= sat_c;
	end

	cst_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s4),
		.s_in    (s_s4),
		.ctl_out (div_ctl),
		.q_out   (div_q)
	);

	cst_horner u_horner (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (div_ctl),
		.q_in    (div_q),
		.ctl_out (hor_ctl),
		.t_out   (hor_t)
	);

	// apply the half-turn sign, then clip the slight overshoot near pi
	always_comb begin
		sgn_c = hor_ctl.neg ? -hor_t : hor_t;
		if (sgn_c > ONE_T)
			sat_c = 32'(ONE_T);
		else if (sgn_c < -ONE_T)
			sat_c = 32'(-ONE_T);
		else
			sat_c = sgn_c[31:0];
	end

	assign done  = done_s14;
	assign value = value_s14;

	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("transfer in did not produce a result after the pipeline latency");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result strobe without a matching input transfer");

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid |-> ({2'b00, r_s3} < cst_pkg::PI_Q))
		else $error("reduced angle not below pi");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (value <= $signed(cst_pkg::Q_ONE) && value >= -$signed(cst_pkg::Q_ONE)))
		else $error("result outside [-1, 1]");

endmodule

@@ test/tb_cosine_sine_taylor_top.sv @@
// Self-checking testbench for the cosine/sine Taylor pipeline: directed table plus random angles.
module tb_cosine_sine_taylor_top;

	// Operation codes on the operation port
	localparam logic OP_COS = cst_pkg::OP_COS;
	localparam logic OP_SIN = cst_pkg::OP_SIN;

	// Angle constants at port width (Q4.28), for the stimulus table
	localparam logic signed [31:0] A_HALF_PI = cst_pkg::HALF_PI_Q;
	localparam logic signed [31:0] A_PI      = cst_pkg::PI_Q;
	localparam logic signed [31:0] A_TWO_PI  = cst_pkg::TWO_PI_Q;
	localparam logic signed [31:0] A_MAX     = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] A_MIN     = 32'sh8000_0000;

	// Results that can be read straight off the formula: exactly +1 and -1 in Q2.30
	localparam logic signed [31:0] V_PLUS_ONE  = cst_pkg::Q_ONE;
	localparam logic signed [31:0] V_MINUS_ONE = -cst_pkg::Q_ONE;

	// 64-bit copies so that all of the predictor's compares stay signed
	localparam longint ONE_Q30  = cst_pkg::Q_ONE;
	localparam longint HALF_PI  = cst_pkg::HALF_PI_Q;
	localparam longint PI       = cst_pkg::PI_Q;
	localparam longint TWO_PI   = cst_pkg::TWO_PI_Q;
	localparam longint HORNER_DIV [7] = '{182, 132, 90, 56, 30, 12, 2};

	localparam int NUM_DIRECTED = 21;
	localparam int NUM_RANDOM   = 1030;
	localparam int IDLE_LIMIT   = 1000;  // cycles with no transfer on either side
	localparam int TAIL_CYCLES  = 30;    // pipeline is 14 deep, leave some margin

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               operation;
	logic signed [31:0] angle;
	logic               done;
	logic signed [31:0] value;

	typedef struct {
		logic               op;
		logic signed [31:0] ang;
		bit                 known;  // val below is the expected result
		logic signed [31:0] val;
	} angle_case_t;

	typedef struct {
		logic               op;
		logic signed [31:0] ang;
		logic signed [31:0] val;
	} cos_sin_due_t;

	// Expected results, oldest first
	cos_sin_due_t pending_values [$];
	int           mismatch_count;
	int           idle_cycles;
	int           burst_left;
	bit           steady;       // no gaps at all while set

	// Directed table. Rows with known set carry a result that follows from the
	// formula by inspection; the rest go through the predictor.
	angle_case_t directed_cases [NUM_DIRECTED] = '{
		'{OP_COS, 32'sd0,                 1'b1, V_PLUS_ONE},   // cos 0
		'{OP_SIN, A_HALF_PI,              1'b1, V_PLUS_ONE},   // offset cancels exactly
		'{OP_COS, A_PI,                   1'b1, V_MINUS_ONE},  // half-turn removed, r = 0
		'{OP_COS, -A_PI,                  1'b1, V_MINUS_ONE},  // negative angle, abs first
		'{OP_COS, A_TWO_PI,               1'b1, V_PLUS_ONE},   // full turn removed
		'{OP_COS, -A_TWO_PI,              1'b1, V_PLUS_ONE},
		'{OP_SIN, A_PI + A_HALF_PI,       1'b1, V_MINUS_ONE},
		'{OP_SIN, A_TWO_PI + A_HALF_PI,   1'b1, V_PLUS_ONE},
		'{OP_COS, A_PI - 32'sd1,          1'b0, 32'sd0},       // series dips below -1: saturation
		'{OP_COS, A_TWO_PI - 32'sd1,      1'b0, 32'sd0},       // negated side, above +1
		'{OP_COS, A_MAX,                  1'b0, 32'sd0},
		'{OP_COS, A_MIN,                  1'b0, 32'sd0},
		'{OP_SIN, A_MAX,                  1'b0, 32'sd0},
		'{OP_SIN, A_MIN,                  1'b0, 32'sd0},       // largest magnitude after offset
		'{OP_SIN, 32'sd0,                 1'b0, 32'sd0},
		'{OP_COS, A_HALF_PI,              1'b0, 32'sd0},
		'{OP_SIN, -A_HALF_PI,             1'b0, 32'sd0},       // 2*(pi/2) is one short of pi
		'{OP_COS, 32'sd1,                 1'b0, 32'sd0},
		'{OP_COS, -32'sd1,                1'b0, 32'sd0},
		'{OP_COS, A_TWO_PI + A_HALF_PI,   1'b0, 32'sd0},
		'{OP_SIN, A_PI,                   1'b0, 32'sd0}
	};

	cosine_sine_taylor_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.angle     (angle),
		.done      (done),
		.value     (value)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Expected Q2.30 result for one angle. Range reduction to [0, pi), then the
	// Horner chain innermost first, every step floored, then sign and saturation.
	function automatic logic signed [31:0] taylor_cos_sin(input logic op,
			input logic signed [31:0] ang);
		longint          a;
		longint          s;
		longint          q;
		longint          tc;
		longint          t;
		longint unsigned ua;
		longint unsigned uq;
		longint unsigned ut;
		longint unsigned p;
		bit              flip;

		a = ang;
		flip = 1'b0;
		if (op == OP_SIN)
			a = a - HALF_PI;
		if (a < 0)
			a = -a;
		if (a >= TWO_PI)
			a = a - TWO_PI;
		if (a >= TWO_PI)
			a = a - TWO_PI;
		if (a >= PI) begin
			a = a - PI;
			flip = 1'b1;
		end
		ua = a;
		s = (ua * ua) >> 26;  // Q.56 square floored to Q.30
		t = ONE_Q30;
		for (int i = 0; i < 7; i++) begin
			q = s / HORNER_DIV[i];
			tc = t;
			if (tc < 0)
				tc = 0;
			if (tc > ONE_Q30)
				tc = ONE_Q30;
			uq = q;
			ut = tc;
			p = (uq * ut) >> 30;
			t = ONE_Q30 - longint'(p);
		end
		if (flip)
			t = -t;
		if (t > ONE_Q30)
			t = ONE_Q30;
		if (t < -ONE_Q30)
			t = -ONE_Q30;
		return t[31:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] ERROR %s", $realtime, what);
		mismatch_count++;
	endtask

	// Present one angle and hold it until the transfer; start stays high so that
	// back-to-back items need no extra edge.
	task automatic send_angle(input logic op, input logic signed [31:0] ang,
			input bit known, input logic signed [31:0] known_val);
		cos_sin_due_t due;

		start     <= 1'b1;
		operation <= op;
		angle     <= ang;
		do
			@(posedge clk);
		while (!(start && !busy));
		due.op  = op;
		due.ang = ang;
		due.val = known ? known_val : taylor_cos_sin(op, ang);
		pending_values.push_back(due);
	endtask

	// Sender pacing after a transfer: bursts of random length, random gaps
	// between them, or a full drain of the pipeline when asked.
	task automatic pace_sender(input bit drain);
		int gap;

		gap = 0;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			if (!steady)
				gap = $urandom_range(0, 16);
		end
		if (drain) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while (pending_values.size() != 0);
		end else if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random angle: full 32-bit range, within one turn either side, or up to 1024
	// LSBs either side of a multiple of pi/2, pi or 2*pi where reduction switches.
	function automatic logic signed [31:0] pick_angle();
		longint base;
		longint sum;
		int     offset;

		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6: begin
				sum = longint'($urandom_range(0, 2 * cst_pkg::TWO_PI_Q)) - TWO_PI;
				return sum[31:0];
			end
			default: begin
				case ($urandom_range(0, 2))
					0: base = longint'(int'($urandom_range(0, 10)) - 5) * HALF_PI;
					1: base = longint'(int'($urandom_range(0, 4)) - 2) * PI;
					default: base = longint'(int'($urandom_range(0, 2)) - 1) * TWO_PI;
				endcase
				offset = int'($urandom_range(0, 2048)) - 1024;
				sum = base + offset;
				if (sum > 64'sd2147483647 || sum < -64'sd2147483648)
					sum = base;
				return sum[31:0];
			end
		endcase
	endfunction

	// Result side: every done cycle is a transfer. The watchdog also lives here.
	always @(posedge clk) begin
		cos_sin_due_t due;

		if ((start && !busy) || done)
			idle_cycles = 0;
		else
			idle_cycles++;

		if (done) begin
			if (pending_values.size() == 0) begin
				report_mismatch($sformatf("result %0d with no angle outstanding", value));
			end else begin
				due = pending_values.pop_front();
				if (value !== due.val)
					report_mismatch($sformatf("op %0d angle %0d: value %0d, want %0d",
						due.op, due.ang, value, due.val));
			end
		end

		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[%0t] ERROR no transfer for %0d cycles", $realtime, IDLE_LIMIT);
			$display("cosine_sine_taylor_top: mismatch");
			$finish;
		end
	end

	initial begin
		mismatch_count = 0;
		idle_cycles    = 0;
		burst_left     = $urandom_range(1, 40);
		steady         = 1'b0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		operation <= OP_COS;
		angle     <= 32'sd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; drain after its last row so the random part starts empty
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_angle(directed_cases[i].op, directed_cases[i].ang,
				directed_cases[i].known, directed_cases[i].val);
			pace_sender(i == NUM_DIRECTED - 1);
		end

		// random part; one stretch runs back to back, one drain in the middle
		for (int i = 0; i < NUM_RANDOM; i++) begin
			steady = (i >= 600 && i < 750);
			send_angle($urandom_range(0, 1) ? OP_SIN : OP_COS, pick_angle(), 1'b0, 32'sd0);
			if (i != NUM_RANDOM - 1)
				pace_sender(i == NUM_RANDOM / 2);
		end
		start <= 1'b0;

		while (pending_values.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("cosine_sine_taylor_top: match");
		else
			$display("cosine_sine_taylor_top: mismatch");
		$finish;
	end

endmodule
